/* sv/hfr_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hfr_pkg
// Shared types and constants of the short-frame receiver: phase codes,
// result kinds, register map and the structs passed between its modules.
// ----------------------------------------------------------------------------
package hfr_pkg;

	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned PRE_LEN_W  = 5;
	localparam int unsigned KIND_W     = 2;
	localparam int unsigned APB_ADDR_W = 3;
	localparam int unsigned APB_DATA_W = 32;

	localparam logic [PRE_LEN_W-1:0] PRE_LEN_RESET = 5'd5;
	localparam logic [BYTE_W-1:0]    DELIM_RESET   = 8'h02;

	// register index, taken from paddr bit 2
	localparam logic REG_PREAMBLE_LENGTH    = 1'b0;
	localparam logic REG_EXPECTED_DELIMITER = 1'b1;

	typedef enum logic [2:0] {
		PH_PREAMBLE = 3'd0,
		PH_ADDR     = 3'd1,
		PH_CMD      = 3'd2,
		PH_COUNT    = 3'd3,
		PH_DATA     = 3'd4,
		PH_CHECK    = 3'd5
	} phase_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_PAYLOAD    = 2'd0,
		KIND_FRAME_DONE = 2'd1,
		KIND_BAD_DELIM  = 2'd2
	} result_kind_t;

	typedef struct packed {
		logic [PRE_LEN_W-1:0] preamble_length;
		logic [BYTE_W-1:0]    expected_delimiter;
	} cfg_t;

	typedef struct packed {
		logic [KIND_W-1:0] result_kind;
		logic [BYTE_W-1:0] payload_byte;
		logic [BYTE_W-1:0] payload_index;
		logic [BYTE_W-1:0] frame_address;
		logic [BYTE_W-1:0] frame_command;
		logic [BYTE_W-1:0] payload_count;
		logic              checksum_ok;
	} result_t;

endpackage
`default_nettype wire

/* sv/hfr_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hfr_if
// Valid/ready channels of the receiver: received bytes in, results out.
// ----------------------------------------------------------------------------
interface hfr_rx_if;
	logic                      valid;
	logic                      ready;
	logic [hfr_pkg::BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface hfr_res_if;
	logic                       valid;
	logic                       ready;
	logic [hfr_pkg::KIND_W-1:0] result_kind;
	logic [hfr_pkg::BYTE_W-1:0] payload_byte;
	logic [hfr_pkg::BYTE_W-1:0] payload_index;
	logic [hfr_pkg::BYTE_W-1:0] frame_address;
	logic [hfr_pkg::BYTE_W-1:0] frame_command;
	logic [hfr_pkg::BYTE_W-1:0] payload_count;
	logic                       checksum_ok;

	modport source (output valid, output result_kind, output payload_byte,
		output payload_index, output frame_address, output frame_command,
		output payload_count, output checksum_ok, input ready);
	modport sink (input valid, input result_kind, input payload_byte,
		input payload_index, input frame_address, input frame_command,
		input payload_count, input checksum_ok, output ready);
endinterface
`default_nettype wire

/* sv/hfr_cfg_regs.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hfr_cfg_regs
// APB register file: preamble length and expected start delimiter.
// ----------------------------------------------------------------------------
module hfr_cfg_regs (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [hfr_pkg::APB_ADDR_W-1:0] paddr,
	input  wire logic [hfr_pkg::APB_DATA_W-1:0] pwdata,
	output logic      [hfr_pkg::APB_DATA_W-1:0] prdata,
	output logic                                pready,
	output hfr_pkg::cfg_t                       cfg
);

	logic [hfr_pkg::PRE_LEN_W-1:0] pre_len_q;
	logic [hfr_pkg::BYTE_W-1:0]    delim_q;
	logic                          wr_en;
	logic                          reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_sel = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_len_q <= hfr_pkg::PRE_LEN_RESET;
			delim_q   <= hfr_pkg::DELIM_RESET;
		end else if (wr_en) begin
			if (reg_sel == hfr_pkg::REG_PREAMBLE_LENGTH) begin
				pre_len_q <= pwdata[hfr_pkg::PRE_LEN_W-1:0];
			end else begin
				delim_q <= pwdata[hfr_pkg::BYTE_W-1:0];
			end
		end
	end

	always_comb begin
		if (reg_sel == hfr_pkg::REG_EXPECTED_DELIMITER) begin
			prdata = {{(hfr_pkg::APB_DATA_W-hfr_pkg::BYTE_W){1'b0}}, delim_q};
		end else begin
			prdata = {{(hfr_pkg::APB_DATA_W-hfr_pkg::PRE_LEN_W){1'b0}}, pre_len_q};
		end
	end

	assign cfg.preamble_length    = pre_len_q;
	assign cfg.expected_delimiter = delim_q;

endmodule
`default_nettype wire

/* sv/hfr_in_stage.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hfr_in_stage
// Input register: captures one received byte and holds it until it advances.
// ----------------------------------------------------------------------------
module hfr_in_stage (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	hfr_rx_if.sink                           rx,
	input  wire logic                        advance,
	output logic                             valid_s1,
	output logic [hfr_pkg::BYTE_W-1:0]       byte_s1
);

	logic accept;

	// take a new byte when the stage is empty or drains this cycle
	assign rx.ready = !valid_s1 || advance;
	assign accept   = rx.valid && rx.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= rx.rx_byte;
		end
	end

endmodule
`default_nettype wire

/* sv/hfr_deframer.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hfr_deframer
// Frame state machine: skips preamble, checks delimiter, captures header,
// tags payload bytes and checks the XOR checksum.
// ----------------------------------------------------------------------------
module hfr_deframer (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  step,
	input  wire logic [hfr_pkg::BYTE_W-1:0] rx_byte,
	input  wire hfr_pkg::cfg_t         cfg,
	output logic                       res_valid,
	output hfr_pkg::result_t           res
);

	hfr_pkg::phase_t           phase_q, phase_d;
	logic [hfr_pkg::BYTE_W-1:0] cnt_q, cnt_d;
	logic [hfr_pkg::BYTE_W-1:0] addr_q, addr_d;
	logic [hfr_pkg::BYTE_W-1:0] cmd_q, cmd_d;
	logic [hfr_pkg::BYTE_W-1:0] count_q, count_d;
	logic [hfr_pkg::BYTE_W-1:0] xor_q, xor_d;
	logic [hfr_pkg::BYTE_W-1:0] cnt_inc;
	logic                       in_preamble;
	logic                       hit;

	assign cnt_inc     = cnt_q + 8'd1;
	assign in_preamble = cnt_q < {{(hfr_pkg::BYTE_W-hfr_pkg::PRE_LEN_W){1'b0}},
		cfg.preamble_length};

	// next state
	always_comb begin
		phase_d = phase_q;
		cnt_d   = cnt_q;
		addr_d  = addr_q;
		cmd_d   = cmd_q;
		count_d = count_q;
		xor_d   = xor_q;
		case (phase_q)
			hfr_pkg::PH_ADDR: begin
				addr_d  = rx_byte;
				xor_d   = xor_q ^ rx_byte;
				phase_d = hfr_pkg::PH_CMD;
			end
			hfr_pkg::PH_CMD: begin
				cmd_d   = rx_byte;
				xor_d   = xor_q ^ rx_byte;
				phase_d = hfr_pkg::PH_COUNT;
			end
			hfr_pkg::PH_COUNT: begin
				count_d = rx_byte;
				xor_d   = xor_q ^ rx_byte;
				cnt_d   = '0;
				phase_d = (rx_byte == '0) ? hfr_pkg::PH_CHECK : hfr_pkg::PH_DATA;
			end
			hfr_pkg::PH_DATA: begin
				xor_d = xor_q ^ rx_byte;
				cnt_d = cnt_inc;
				if (cnt_inc >= count_q) begin
					phase_d = hfr_pkg::PH_CHECK;
				end
			end
			hfr_pkg::PH_CHECK: begin
				phase_d = hfr_pkg::PH_PREAMBLE;
				cnt_d   = '0;
			end
			default: begin
				// preamble, and any code that means nothing
				phase_d = hfr_pkg::PH_PREAMBLE;
				if (in_preamble) begin
					cnt_d = cnt_inc;
				end else begin
					cnt_d = '0;
					if (rx_byte == cfg.expected_delimiter) begin
						xor_d   = rx_byte;
						phase_d = hfr_pkg::PH_ADDR;
					end
				end
			end
		endcase
	end

	// result
	always_comb begin
		hit = 1'b0;
		res = '0;
		case (phase_q)
			hfr_pkg::PH_DATA: begin
				hit               = 1'b1;
				res.result_kind   = hfr_pkg::KIND_PAYLOAD;
				res.payload_byte  = rx_byte;
				res.payload_index = cnt_q;
				res.frame_address = addr_q;
				res.frame_command = cmd_q;
				res.payload_count = count_q;
			end
			hfr_pkg::PH_CHECK: begin
				hit               = 1'b1;
				res.result_kind   = hfr_pkg::KIND_FRAME_DONE;
				res.frame_address = addr_q;
				res.frame_command = cmd_q;
				res.payload_count = count_q;
				res.checksum_ok   = (rx_byte == xor_q);
			end
			hfr_pkg::PH_ADDR, hfr_pkg::PH_CMD, hfr_pkg::PH_COUNT: begin
				hit = 1'b0;
			end
			default: begin
				if (!in_preamble && (rx_byte != cfg.expected_delimiter)) begin
					hit             = 1'b1;
					res.result_kind = hfr_pkg::KIND_BAD_DELIM;
				end
			end
		endcase
	end

	assign res_valid = step && hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= hfr_pkg::PH_PREAMBLE;
			cnt_q   <= '0;
			addr_q  <= '0;
			cmd_q   <= '0;
			count_q <= '0;
			xor_q   <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			addr_q  <= addr_d;
			cmd_q   <= cmd_d;
			count_q <= count_d;
			xor_q   <= xor_d;
		end
	end

endmodule
`default_nettype wire

/* sv/hfr_out_reg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hfr_out_reg
// Result register: holds one result until the sink takes it.
// ----------------------------------------------------------------------------
module hfr_out_reg (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        load,
	input  wire hfr_pkg::result_t res,
	output logic             free,
	hfr_res_if.source        out
);

	logic             valid_q;
	hfr_pkg::result_t data_q;

	assign free = !valid_q || out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= res;
		end
	end

	assign out.valid         = valid_q;
	assign out.result_kind   = data_q.result_kind;
	assign out.payload_byte  = data_q.payload_byte;
	assign out.payload_index = data_q.payload_index;
	assign out.frame_address = data_q.frame_address;
	assign out.frame_command = data_q.frame_command;
	assign out.payload_count = data_q.payload_count;
	assign out.checksum_ok   = data_q.checksum_ok;

endmodule
`default_nettype wire

/* sv/hart_frame_receiver_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hart_frame_receiver_top
// Short-frame deframer with XOR checksum, one received byte per item.
// ----------------------------------------------------------------------------
// The receiver takes one byte per clock and gives at most one result item per
// byte. Each byte passes an input register, the frame logic and a result
// register; its result is offered from the result register once the input
// register has advanced the byte through the frame logic.
// Throughput is one byte per cycle as long as the result sink keeps up; a byte
// waits in the input register only while the result register holds an item
// that has not been taken. A frame is: preamble_length bytes that are skipped
// unchecked, the start delimiter (compared with expected_delimiter; a mismatch
// gives a bad-delimiter item and restarts at the preamble), address, command,
// byte count, the payload bytes (each given as a payload item with its index
// and the header fields) and a checksum byte, which gives a frame-complete item
// with checksum_ok set when it equals the XOR of delimiter, header and payload.
// A zero byte count goes straight to the checksum. Program the two registers
// over APB (preamble length at 0x0, delimiter at 0x4) only while the block is
// idle; a new value applies from the next byte.
// ----------------------------------------------------------------------------
module hart_frame_receiver_top (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	hfr_rx_if.sink                              rx,
	hfr_res_if.source                           res,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [hfr_pkg::APB_ADDR_W-1:0] paddr,
	input  wire logic [hfr_pkg::APB_DATA_W-1:0] pwdata,
	output logic      [hfr_pkg::APB_DATA_W-1:0] prdata,
	output logic                                pready
);

	hfr_pkg::cfg_t              cfg;
	hfr_pkg::result_t           result;
	logic                       valid_s1;
	logic [hfr_pkg::BYTE_W-1:0] byte_s1;
	logic                       advance;
	logic                       out_free;
	logic                       res_load;

	// register file
	hfr_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// advance the held byte through the frame logic when the result slot is
	// free; bytes that give no result advance under the same rule
	assign advance = valid_s1 && out_free;

	hfr_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx       (rx),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	hfr_deframer u_deframer (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.rx_byte   (byte_s1),
		.cfg       (cfg),
		.res_valid (res_load),
		.res       (result)
	);

	hfr_out_reg u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (res_load),
		.res    (result),
		.free   (out_free),
		.out    (res)
	);

endmodule
`default_nettype wire
